FILE: hw/rtl/arht_pkg.sv
package arht_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 16;
   localparam int unsigned ADDR_W            = 64;
   localparam int unsigned STATUS_W          = 3;
   localparam int unsigned COUNT_OUT_W       = 5;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_ALREADY  = 3'd1,
      STATUS_INVALID  = 3'd2,
      STATUS_RELEASED = 3'd3,
      STATUS_NOTFOUND = 3'd4,
      STATUS_PARTIAL  = 3'd5,
      STATUS_FULL     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FINISH
   } seq_state_type;

   // Relation of one stored range to the requested span.
   typedef struct packed {
      logic same;        // identical begin and end
      logic overlap;     // shares at least one byte with the span
      logic contained;   // lies wholly inside the span
   } cmp_result_type;

endpackage

FILE: hw/rtl/arht_store.sv
module arht_store #(
   parameter int unsigned TABLE_ENTRIES = arht_pkg::TABLE_ENTRIES_DEF,
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic [IDX_W-1:0]            rd_idx,
   output logic [arht_pkg::ADDR_W-1:0] rd_begin,
   output logic [arht_pkg::ADDR_W-1:0] rd_end,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [arht_pkg::ADDR_W-1:0] wr_begin,
   input  logic [arht_pkg::ADDR_W-1:0] wr_end
);

   logic [arht_pkg::ADDR_W-1:0] begin_mem [TABLE_ENTRIES];
   logic [arht_pkg::ADDR_W-1:0] end_mem   [TABLE_ENTRIES];
   logic [arht_pkg::ADDR_W-1:0] rd_begin_ff;
   logic [arht_pkg::ADDR_W-1:0] rd_end_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         begin_mem[wr_idx] <= wr_begin;
         end_mem[wr_idx]   <= wr_end;
      end
      rd_begin_ff <= begin_mem[rd_idx];
      rd_end_ff   <= end_mem[rd_idx];
   end

   assign rd_begin = rd_begin_ff;
   assign rd_end   = rd_end_ff;

endmodule

FILE: hw/rtl/arht_cmp.sv
module arht_cmp (
   input  logic [arht_pkg::ADDR_W-1:0] ent_begin,
   input  logic [arht_pkg::ADDR_W-1:0] ent_end,
   input  logic [arht_pkg::ADDR_W-1:0] span_lo,
   input  logic [arht_pkg::ADDR_W-1:0] span_hi,
   output arht_pkg::cmp_result_type    result
);

   logic begin_ge_lo;
   logic end_le_hi;
   logic begin_lt_hi;
   logic lo_lt_end;

   always_comb begin
      begin_ge_lo      = (ent_begin >= span_lo);
      end_le_hi        = (ent_end <= span_hi);
      begin_lt_hi      = (ent_begin < span_hi);
      lo_lt_end        = (span_lo < ent_end);
      result.same      = (ent_begin == span_lo) && (ent_end == span_hi);
      result.overlap   = begin_lt_hi && lo_lt_end;
      result.contained = begin_ge_lo && end_le_hi;
   end

endmodule

FILE: hw/rtl/arht_ctrl.sv
module arht_ctrl #(
   parameter int unsigned TABLE_ENTRIES = arht_pkg::TABLE_ENTRIES_DEF,
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [arht_pkg::ADDR_W-1:0]      req_base_address,
   input  logic [arht_pkg::ADDR_W-1:0]      req_length_bytes,
   output logic                             rsp_valid,
   output logic [arht_pkg::STATUS_W-1:0]    rsp_status,
   output logic [arht_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [IDX_W-1:0]                 rd_idx,
   output logic                             wr_en,
   output logic [IDX_W-1:0]                 wr_idx,
   output logic [arht_pkg::ADDR_W-1:0]      span_lo,
   output logic [arht_pkg::ADDR_W-1:0]      span_hi,
   input  arht_pkg::cmp_result_type         cmp_res
);

   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   arht_pkg::seq_state_type state_ff, state_in;

   logic                        mode_ff, mode_in;
   logic [arht_pkg::ADDR_W-1:0] lo_ff, lo_in;
   logic [arht_pkg::ADDR_W-1:0] hi_ff, hi_in;
   logic                        bad_ff, bad_in;
   logic [IDX_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        issue_ff, issue_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                        dup_ff, dup_in;
   logic                        partial_ff, partial_in;
   logic                        hit_ff, hit_in;
   logic                        free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0]    kill_ff, kill_in;
   logic [CNT_W-1:0]            kill_cnt_ff, kill_cnt_in;
   logic [TABLE_ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   arht_pkg::status_type        rsp_status_ff, rsp_status_in;

   logic [arht_pkg::ADDR_W:0]   span_sum;
   logic                        ent_valid;
   logic [CNT_W+arht_pkg::COUNT_OUT_W-1:0] count_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arht_pkg::SEQ_IDLE;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      bad_ff        <= bad_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      dup_ff        <= dup_in;
      partial_ff    <= partial_in;
      hit_ff        <= hit_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      kill_ff       <= kill_in;
      kill_cnt_ff   <= kill_cnt_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      bad_in        = bad_ff;
      rd_idx_in     = rd_idx_ff;
      issue_in      = 1'b0;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = rd_idx_ff;
      dup_in        = dup_ff;
      partial_in    = partial_ff;
      hit_in        = hit_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      kill_in       = kill_ff;
      kill_cnt_in   = kill_cnt_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      ent_valid     = valid_ff[cmp_idx_ff];
      span_sum      = {1'b0, req_base_address} + {1'b0, req_length_bytes};

      unique case (state_ff)
         arht_pkg::SEQ_IDLE: begin
            if (start) begin
               // Capture the span; a carry out means the end passes the top.
               mode_in     = req_mode;
               lo_in       = req_base_address;
               hi_in       = span_sum[arht_pkg::ADDR_W-1:0];
               bad_in      = (req_length_bytes == '0) || span_sum[arht_pkg::ADDR_W];
               rd_idx_in   = '0;
               issue_in    = 1'b1;
               dup_in      = 1'b0;
               partial_in  = 1'b0;
               hit_in      = 1'b0;
               free_ok_in  = 1'b0;
               free_idx_in = '0;
               kill_in     = '0;
               kill_cnt_in = '0;
               state_in    = arht_pkg::SEQ_SCAN;
            end
         end

         arht_pkg::SEQ_SCAN: begin
            if (bad_ff) begin
               state_in = arht_pkg::SEQ_FINISH;
            end else begin
               // Advance the read address; the compare follows in the next cycle.
               if (issue_ff) begin
                  cmp_vld_in = 1'b1;
                  if (rd_idx_ff != LAST_IDX) begin
                     issue_in  = 1'b1;
                     rd_idx_in = rd_idx_ff + IDX_W'(1);
                  end
               end
               if (cmp_vld_ff) begin
                  if (ent_valid && cmp_res.same) begin
                     dup_in = 1'b1;
                  end
                  if (!ent_valid && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
                  if (ent_valid && cmp_res.overlap) begin
                     hit_in = 1'b1;
                     if (!cmp_res.contained) begin
                        partial_in = 1'b1;
                     end
                  end
                  if (ent_valid && cmp_res.contained) begin
                     kill_in[cmp_idx_ff] = 1'b1;
                     kill_cnt_in         = kill_cnt_ff + CNT_W'(1);
                  end
                  if (cmp_idx_ff == LAST_IDX) begin
                     state_in = arht_pkg::SEQ_FINISH;
                  end
               end
            end
         end

         arht_pkg::SEQ_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = arht_pkg::SEQ_IDLE;
            priority if (bad_ff) begin
               rsp_status_in = arht_pkg::STATUS_INVALID;
            end else if (!mode_ff) begin
               priority if (dup_ff) begin
                  rsp_status_in = arht_pkg::STATUS_ALREADY;
               end else if (!free_ok_ff) begin
                  rsp_status_in = arht_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in         = arht_pkg::STATUS_INSERTED;
                  wr_en                 = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + CNT_W'(1);
               end
            end else begin
               priority if (partial_ff) begin
                  rsp_status_in = arht_pkg::STATUS_PARTIAL;
               end else if (!hit_ff) begin
                  rsp_status_in = arht_pkg::STATUS_NOTFOUND;
               end else begin
                  rsp_status_in = arht_pkg::STATUS_RELEASED;
                  valid_in      = valid_ff & ~kill_ff;
                  count_in      = count_ff - kill_cnt_ff;
               end
            end
         end

         default: begin
            state_in = arht_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign count_wide      = {{arht_pkg::COUNT_OUT_W{1'b0}}, count_ff};
   assign busy            = (state_ff != arht_pkg::SEQ_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = count_wide[arht_pkg::COUNT_OUT_W-1:0];
   assign rd_idx          = rd_idx_ff;
   assign wr_idx          = free_idx_ff;
   assign span_lo         = lo_ff;
   assign span_hi         = hi_ff;

endmodule

FILE: hw/rtl/address_range_hole_table.sv
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------------------------
// request   | req_mode, req_base_address, req_length_bytes   | taken when start && !busy
// response  | rsp_status, rsp_entry_count                    | one cycle under rsp_valid
//
// A valid request reads the first entry, then makes one pass over the range memory,
// one entry per cycle through a single read port and one shared comparator,
// then commits in the finish state and shows its response from a register. An
// invalid request skips the pass and goes from the scan state to the finish state.
// busy drops in the response cycle, so the next request may be taken there.
// Reset clears the valid marks and the entry count; no clearing pass is needed.
// The receiver cannot stall; a response is shown for exactly one cycle.
module address_range_hole_table #(
   parameter int unsigned TABLE_ENTRIES = arht_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [arht_pkg::ADDR_W-1:0]      req_base_address,
   input  logic [arht_pkg::ADDR_W-1:0]      req_length_bytes,
   output logic                             rsp_valid,
   output logic [arht_pkg::STATUS_W-1:0]    rsp_status,
   output logic [arht_pkg::COUNT_OUT_W-1:0] rsp_entry_count
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [IDX_W-1:0]            rd_idx;
   logic [IDX_W-1:0]            wr_idx;
   logic                        wr_en;
   logic [arht_pkg::ADDR_W-1:0] span_lo;
   logic [arht_pkg::ADDR_W-1:0] span_hi;
   logic [arht_pkg::ADDR_W-1:0] ent_begin;
   logic [arht_pkg::ADDR_W-1:0] ent_end;
   arht_pkg::cmp_result_type    cmp_res;

   // Sequence the scan, hold valid marks and count, and form the response.
   arht_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_base_address (req_base_address),
      .req_length_bytes (req_length_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rd_idx           (rd_idx),
      .wr_en            (wr_en),
      .wr_idx           (wr_idx),
      .span_lo          (span_lo),
      .span_hi          (span_hi),
      .cmp_res          (cmp_res)
   );

   // Hold range begin and end; write on insert, read one entry per cycle.
   arht_store #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_store (
      .clock    (clock),
      .rd_idx   (rd_idx),
      .rd_begin (ent_begin),
      .rd_end   (ent_end),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_begin (span_lo),
      .wr_end   (span_hi)
   );

   // Compare the entry just read against the requested span.
   arht_cmp u_cmp (
      .ent_begin (ent_begin),
      .ent_end   (ent_end),
      .span_lo   (span_lo),
      .span_hi   (span_hi),
      .result    (cmp_res)
   );

endmodule

FILE: hw/rtl/arht_checker.sv
module arht_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [arht_pkg::STATUS_W-1:0]    rsp_status,
   input logic [arht_pkg::COUNT_OUT_W-1:0] rsp_entry_count
);

   // Every request yields one response, never two in a row.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // The entry count moves only together with a response.
   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> $stable(rsp_entry_count))
      else $error("entry count changed without a response");

   a_done_with_response: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= arht_pkg::STATUS_FULL))
      else $error("response status out of range");

endmodule

bind address_range_hole_table arht_checker u_arht_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);

FILE: dv/address_range_hole_table_tb.sv
// Keeps its own copy of the range table and predicts status and count for
// every accepted request.
class range_table_scoreboard;
   typedef struct packed {
      arht_pkg::status_type                     status;
      logic [arht_pkg::COUNT_OUT_W-1:0]         count;
   } outcome_type;

   logic [63:0]  slot_begin [arht_pkg::TABLE_ENTRIES_DEF];
   logic [63:0]  slot_end   [arht_pkg::TABLE_ENTRIES_DEF];
   bit           slot_valid [arht_pkg::TABLE_ENTRIES_DEF];
   outcome_type  awaited_responses[$];
   int           answered;
   int           mismatches;

   function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      answered   = 0;
      mismatches = 0;
   endfunction

   function arht_pkg::status_type predict_register(logic [63:0] lo, logic [63:0] hi);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < arht_pkg::TABLE_ENTRIES_DEF; i++) begin
         if (slot_valid[i]) begin
            if (slot_begin[i] == lo && slot_end[i] == hi) return arht_pkg::STATUS_ALREADY;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (free_slot < 0) return arht_pkg::STATUS_FULL;
      slot_begin[free_slot] = lo;
      slot_end[free_slot]   = hi;
      slot_valid[free_slot] = 1'b1;
      return arht_pkg::STATUS_INSERTED;
   endfunction

   function arht_pkg::status_type predict_release(logic [63:0] lo, logic [63:0] hi);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < arht_pkg::TABLE_ENTRIES_DEF; i++) begin
         if (!slot_valid[i]) continue;
         if (slot_begin[i] >= hi || lo >= slot_end[i]) continue;
         if (slot_begin[i] < lo || slot_end[i] > hi) return arht_pkg::STATUS_PARTIAL;
         hit = 1'b1;
      end
      if (!hit) return arht_pkg::STATUS_NOTFOUND;
      for (int i = 0; i < arht_pkg::TABLE_ENTRIES_DEF; i++) begin
         if (slot_valid[i] && slot_begin[i] >= lo && slot_end[i] <= hi) slot_valid[i] = 1'b0;
      end
      return arht_pkg::STATUS_RELEASED;
   endfunction

   function void note_request(logic mode, logic [63:0] base, logic [63:0] len);
      outcome_type want;
      int          live;
      // ~base is the room left up to the top address
      if (len == 64'd0 || len > ~base) begin
         want.status = arht_pkg::STATUS_INVALID;
      end else if (mode == 1'b0) begin
         want.status = predict_register(base, base + len);
      end else begin
         want.status = predict_release(base, base + len);
      end
      live = 0;
      foreach (slot_valid[i]) if (slot_valid[i]) live++;
      want.count = live[arht_pkg::COUNT_OUT_W-1:0];
      awaited_responses.push_back(want);
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   task check_response(logic [arht_pkg::STATUS_W-1:0] status,
                       logic [arht_pkg::COUNT_OUT_W-1:0] count);
      outcome_type want;
      answered++;
      if (awaited_responses.size() == 0) begin
         report_mismatch($sformatf("unexpected response status %0d count %0d", status, count));
         return;
      end
      want = awaited_responses.pop_front();
      if (status !== want.status)
         report_mismatch($sformatf("response %0d status %0d, predicted %0d",
                                   answered, status, want.status));
      if (count !== want.count)
         report_mismatch($sformatf("response %0d entry count %0d, predicted %0d",
                                   answered, count, want.count));
   endtask

   task close_out();
      if (awaited_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", awaited_responses.size()));
   endtask
endclass

module address_range_hole_table_tb;

   localparam int unsigned     SLOTS           = arht_pkg::TABLE_ENTRIES_DEF;
   localparam int unsigned     RANDOM_REQUESTS = 1750;
   localparam int unsigned     PHASE_LENGTH    = 125;
   // longest request latency plus some margin
   localparam int unsigned     SETTLE_CYCLES   = SLOTS + 6;
   localparam int unsigned     CYCLE_LIMIT     = 400000;
   localparam logic [63:0]     ADDR_MAX        = {64{1'b1}};

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic                             req_mode;
   logic [arht_pkg::ADDR_W-1:0]      req_base_address;
   logic [arht_pkg::ADDR_W-1:0]      req_length_bytes;
   logic                             rsp_valid;
   logic [arht_pkg::STATUS_W-1:0]    rsp_status;
   logic [arht_pkg::COUNT_OUT_W-1:0] rsp_entry_count;

   range_table_scoreboard board;
   int unsigned           cycle_count;
   int                    issued;

   // Address window that the random requests of one phase fall into.
   logic [63:0] win_base;
   logic [63:0] win_unit;
   int          reg_percent;
   bit          idle_on;

   // Recently registered ranges, reused to provoke duplicates.
   logic [63:0] recent_base [8];
   logic [63:0] recent_len  [8];
   int          recent_fill;
   int          recent_next;

   address_range_hole_table DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_base_address (req_base_address),
      .req_length_bytes (req_length_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hold every input at a known value from time zero.
   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = 1'b0;
      req_base_address = '0;
      req_length_bytes = '0;
      board            = new();
      issued           = 0;
      recent_fill      = 0;
      recent_next      = 0;
      idle_on          = 1'b1;
   end

   // Watchdog: give up well past the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end
   initial cycle_count = 0;

   // Sample both channels on the edge that accepts them. Check the response
   // first: a request taken in the response cycle comes after it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_response(rsp_status, rsp_entry_count);
         if (start && !busy) board.note_request(req_mode, req_base_address, req_length_bytes);
      end
   end

   // Present one request after a random gap and hold it until taken. With no
   // gap, start stays high and only the fields change.
   task automatic send_request(input logic mode, input logic [63:0] base,
                               input logic [63:0] len);
      int gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_mode         <= mode;
      req_base_address <= base;
      req_length_bytes <= len;
      issued++;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every request has been answered.
   task automatic wait_for_responses();
      start <= 1'b0;
      while (board.answered < issued) @(posedge clock);
   endtask

   // Clear the whole table: every stored range lies inside [0, max).
   task automatic wipe_table();
      send_request(1'b1, 64'd0, ADDR_MAX);
   endtask

   // Now and then shave one byte off a length, to make near misses.
   function automatic logic [63:0] trim_byte();
      return ($urandom_range(0, 3) == 0) ? 64'd1 : 64'd0;
   endfunction

   task automatic issue_random_request();
      int          pick;
      int          k;
      logic        mode;
      logic [63:0] base;
      logic [63:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         // Invalid lengths: zero, or running past the top address; now and
         // then exactly up to the top, which is still allowed.
         mode = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: begin
               base = {$urandom, $urandom};
               len  = 64'd0;
            end
            1: begin
               base = ADDR_MAX - 64'($urandom_range(0, 7));
               len  = (ADDR_MAX - base) + 64'd1 + 64'($urandom_range(0, 7));
            end
            2: begin
               base = {$urandom, $urandom};
               len  = ~base + 64'd1 + 64'($urandom_range(0, 15));
            end
            default: begin
               base = {$urandom, $urandom};
               len  = ~base;
            end
         endcase
      end else if (pick < 12) begin
         // Noise over the full width of every field.
         mode = 1'($urandom_range(0, 1));
         base = {$urandom, $urandom};
         len  = {$urandom, $urandom};
      end else if (pick == 12) begin
         mode = 1'b1;
         base = 64'd0;
         len  = ADDR_MAX;
      end else if ($urandom_range(0, 99) < reg_percent) begin
         mode = 1'b0;
         if (recent_fill != 0 && $urandom_range(0, 5) == 0) begin
            k    = $urandom_range(0, recent_fill - 1);
            base = recent_base[k];
            len  = recent_len[k];
         end else begin
            base = win_base + win_unit * 64'($urandom_range(0, 15));
            len  = win_unit * 64'($urandom_range(1, 4)) - trim_byte();
            recent_base[recent_next] = base;
            recent_len[recent_next]  = len;
            recent_next = (recent_next + 1) % 8;
            if (recent_fill < 8) recent_fill++;
         end
      end else begin
         mode = 1'b1;
         base = win_base + win_unit * 64'($urandom_range(0, 15));
         len  = win_unit * 64'($urandom_range(1, 8)) - trim_byte();
      end
      send_request(mode, base, len);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: invalid in both modes, a range running past the top, a range
      // ending at the top address, duplicate, straddling release, fill to full,
      // duplicate on a full table, insert into a full table, release all, empty release.
      send_request(1'b0, 64'h1234, 64'd0);
      send_request(1'b1, 64'h1234, 64'd0);
      send_request(1'b0, ADDR_MAX, 64'd1);
      send_request(1'b0, 64'd0, ADDR_MAX);
      send_request(1'b0, 64'd0, ADDR_MAX);
      send_request(1'b1, 64'd100, 64'd10);
      for (int i = 1; i < SLOTS; i++) send_request(1'b0, 64'(i) * 64'd16, 64'd16);
      send_request(1'b0, 64'd80, 64'd16);
      send_request(1'b0, 64'd4096, 64'd1);
      send_request(1'b1, 64'd0, ADDR_MAX);
      send_request(1'b1, 64'd0, 64'd5);
      wait_for_responses();

      // Random part in phases; each phase moves the window, changes the mix
      // of register and release, and drains before the next one.
      for (int phase = 0; phase < RANDOM_REQUESTS / PHASE_LENGTH; phase++) begin
         case ($urandom_range(0, 3))
            0:       win_unit = 64'd1;
            1:       win_unit = 64'd16;
            2:       win_unit = 64'd4096;
            default: win_unit = ({$urandom, $urandom} >> $urandom_range(8, 40)) | 64'd1;
         endcase
         case ($urandom_range(0, 2))
            0:       win_base = 64'd0;
            1:       win_base = {$urandom, $urandom} & ~64'hFFFF;
            default: win_base = 64'd0 - win_unit * 64'd20;   // ends reach the top
         endcase
         case ($urandom_range(0, 2))
            0:       reg_percent = 35;
            1:       reg_percent = 55;
            default: reg_percent = 80;
         endcase
         idle_on     = (phase % 3) != 2;
         recent_fill = 0;
         wipe_table();
         for (int n = 1; n < PHASE_LENGTH; n++) issue_random_request();
         wait_for_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      board.close_out();
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/arht_pkg.sv
hw/rtl/arht_store.sv
hw/rtl/arht_cmp.sv
hw/rtl/arht_ctrl.sv
hw/rtl/address_range_hole_table.sv
hw/rtl/arht_checker.sv
dv/address_range_hole_table_tb.sv
